@@ sv/aft_pkg.sv @@
// Shared types, constants and helper functions of the fetch queue depth tuner.
`timescale 1ns / 1ps
`default_nettype none

package aft_pkg;

  // Default sizes of the tuner.
  localparam int unsigned QUEUE_CAPACITY_DEF   = 64;
  localparam int unsigned INFLIGHT_ENTRIES_DEF = 64;
  localparam int unsigned LINE_ADDR_BITS_DEF   = 42;

  // Fixed field widths.
  localparam int unsigned DEPTH_W    = 7;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned TGT_W      = 11;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned TERM_W     = 3;
  localparam int unsigned NUM_TERMS  = 5;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_POLICY    = 3'd0;
  localparam logic [2:0] REG_INIT      = 3'd1;
  localparam logic [2:0] REG_MIN       = 3'd2;
  localparam logic [2:0] REG_MAX       = 3'd3;
  localparam logic [2:0] REG_STEP      = 3'd4;
  localparam logic [2:0] REG_WINDOW    = 3'd5;
  localparam logic [2:0] REG_TGT_UTIL  = 3'd6;
  localparam logic [2:0] REG_TGT_TIME  = 3'd7;

  // Register reset values.
  localparam logic [MODE_W-1:0]  RST_POLICY     = 2'd2;
  localparam logic [DEPTH_W-1:0] RST_INIT_DEPTH = 7'd16;
  localparam logic [DEPTH_W-1:0] RST_MIN_DEPTH  = 7'd4;
  localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH  = 7'd64;
  localparam logic [DEPTH_W-1:0] RST_STEP       = 7'd4;
  localparam logic [WIN_W-1:0]   RST_WINDOW     = 16'd256;
  localparam logic [TGT_W-1:0]   RST_TGT_UTIL   = 11'd512;
  localparam logic [TGT_W-1:0]   RST_TGT_TIME   = 11'd512;

  // Policy codes.
  localparam logic [MODE_W-1:0] POL_UTIL = 2'd0;
  localparam logic [MODE_W-1:0] POL_TIME = 2'd1;
  localparam logic [MODE_W-1:0] POL_BOTH = 2'd2;
  localparam logic [MODE_W-1:0] POL_RSVD = 2'd3;

  // Search direction codes.
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Event kinds.
  typedef enum logic [1:0] {
    CMD_DEMAND = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_UNUSED = 2'd2,
    CMD_ISSUE  = 2'd3
  } cmd_e;

  // Configuration register set.
  typedef struct packed {
    logic [MODE_W-1:0]  policy;
    logic [DEPTH_W-1:0] init_depth;
    logic [DEPTH_W-1:0] lo_depth;
    logic [DEPTH_W-1:0] hi_depth;
    logic [DEPTH_W-1:0] step;
    logic [WIN_W-1:0]   window;
    logic [TGT_W-1:0]   tgt_util;
    logic [TGT_W-1:0]   tgt_time;
  } cfg_t;

  // Flags of an incoming event that steer the controller.
  typedef struct packed {
    cmd_e cmd;
    logic pref;
    logic miss;
    logic mq;
  } evt_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              inc_pref_hit;
    logic              inc_unused;
    logic              inc_late_hit;
    logic              scan_step;
    logic              scan_insert;
    logic              table_commit;
    logic              issue_step;
    logic              eval_mul;
    logic              eval_seek;
    logic              reg_mul;
    logic              reg_acc;
    logic              reg_fin;
    logic [TERM_W-1:0] term;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic found;
    logic win_close;
    logic regress;
  } stat_t;

  // A zero lower bound counts as one.
  function automatic logic [DEPTH_W-1:0] eff_min(input logic [DEPTH_W-1:0] m);
    return (m == '0) ? DEPTH_W'(1) : m;
  endfunction

  // Raise to the lower bound first, then lower to the upper bound.
  function automatic logic [DEPTH_W-1:0] clamp_depth(input logic [9:0] d,
                                                     input logic [DEPTH_W-1:0] lo,
                                                     input logic [DEPTH_W-1:0] hi);
    logic [9:0] v;
    v = d;
    if (v < {3'b000, lo}) v = {3'b000, lo};
    if (v > {3'b000, hi}) v = {3'b000, hi};
    return v[DEPTH_W-1:0];
  endfunction

  // Saturating event counter increment.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  // Q16 coefficients of the regression terms a, t, a*a, t*t, a*t.
  function automatic logic signed [16:0] term_coef(input logic [TERM_W-1:0] k);
    logic signed [16:0] c;
    case (k)
      3'd0:    c = -17'sd22282;
      3'd1:    c = 17'sd41943;
      3'd2:    c = 17'sd524;
      3'd3:    c = 17'sd655;
      3'd4:    c = -17'sd524;
      default: c = 17'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/aft_regs.sv @@
// Configuration register file on the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module aft_regs
  import aft_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o,
  output logic                       init_load_o
);

  cfg_t       cfg_q, cfg_d;
  logic       init_load_q, init_load_d;
  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // Register writes.
  always_comb begin
    cfg_d       = cfg_q;
    init_load_d = 1'b0;
    if (wr) begin
      case (idx)
        REG_POLICY:   cfg_d.policy     = pwdata[MODE_W-1:0];
        REG_INIT: begin
          cfg_d.init_depth = pwdata[DEPTH_W-1:0];
          init_load_d      = 1'b1;
        end
        REG_MIN:      cfg_d.lo_depth   = pwdata[DEPTH_W-1:0];
        REG_MAX:      cfg_d.hi_depth   = pwdata[DEPTH_W-1:0];
        REG_STEP:     cfg_d.step       = pwdata[DEPTH_W-1:0];
        REG_WINDOW:   cfg_d.window     = pwdata[WIN_W-1:0];
        REG_TGT_UTIL: cfg_d.tgt_util   = pwdata[TGT_W-1:0];
        REG_TGT_TIME: cfg_d.tgt_time   = pwdata[TGT_W-1:0];
        default:      cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.policy     <= RST_POLICY;
      cfg_q.init_depth <= RST_INIT_DEPTH;
      cfg_q.lo_depth   <= RST_MIN_DEPTH;
      cfg_q.hi_depth   <= RST_MAX_DEPTH;
      cfg_q.step       <= RST_STEP;
      cfg_q.window     <= RST_WINDOW;
      cfg_q.tgt_util   <= RST_TGT_UTIL;
      cfg_q.tgt_time   <= RST_TGT_TIME;
      init_load_q      <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      init_load_q <= init_load_d;
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      REG_POLICY:   prdata = APB_DATA_W'(cfg_q.policy);
      REG_INIT:     prdata = APB_DATA_W'(cfg_q.init_depth);
      REG_MIN:      prdata = APB_DATA_W'(cfg_q.lo_depth);
      REG_MAX:      prdata = APB_DATA_W'(cfg_q.hi_depth);
      REG_STEP:     prdata = APB_DATA_W'(cfg_q.step);
      REG_WINDOW:   prdata = APB_DATA_W'(cfg_q.window);
      REG_TGT_UTIL: prdata = APB_DATA_W'(cfg_q.tgt_util);
      REG_TGT_TIME: prdata = APB_DATA_W'(cfg_q.tgt_time);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o       = cfg_q;
  assign init_load_o = init_load_q;

endmodule

`default_nettype wire

@@ sv/aft_datapath.sv @@
// Datapath: in-flight line table, window counters, depth search and regression.
`timescale 1ns / 1ps
`default_nettype none

module aft_datapath
  import aft_pkg::*;
#(
  parameter int unsigned QUEUE_CAPACITY   = QUEUE_CAPACITY_DEF,
  parameter int unsigned INFLIGHT_ENTRIES = INFLIGHT_ENTRIES_DEF,
  parameter int unsigned LINE_ADDR_BITS   = LINE_ADDR_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cfg_t                      cfg_i,
  input  wire logic                      init_load_i,
  input  wire ctrl_t                     ctrl_i,
  input  wire logic [LINE_ADDR_BITS-1:0] line_addr_i,
  output stat_t                          stat_o,
  output logic      [DEPTH_W-1:0]        depth_o,
  output logic                           depth_changed_o,
  output logic                           window_closed_o,
  output logic                           search_stage_o
);

  localparam int unsigned IDX_W  = $clog2(INFLIGHT_ENTRIES);
  localparam int unsigned SCNT_W = $clog2(INFLIGHT_ENTRIES + 1);
  localparam logic [SCNT_W-1:0] SCAN_END = SCNT_W'(INFLIGHT_ENTRIES);
  localparam logic [TERM_W-1:0] TERM_A   = TERM_W'(0);
  localparam logic [TERM_W-1:0] TERM_T   = TERM_W'(1);
  localparam logic [TERM_W-1:0] TERM_AA  = TERM_W'(2);
  localparam logic [TERM_W-1:0] TERM_TT  = TERM_W'(3);

  // Upper bound limited to the queue capacity; zero counts as one.
  function automatic logic [DEPTH_W-1:0] eff_max(input logic [DEPTH_W-1:0] m);
    logic [DEPTH_W-1:0] r;
    r = m;
    if (32'(m) > QUEUE_CAPACITY) r = DEPTH_W'(QUEUE_CAPACITY);
    if (r == '0) r = DEPTH_W'(1);
    return r;
  endfunction

  // Line table storage and scan pipeline.
  logic [LINE_ADDR_BITS-1:0]   mem [INFLIGHT_ENTRIES];
  logic [INFLIGHT_ENTRIES-1:0] valid_q, valid_d;
  logic [LINE_ADDR_BITS-1:0]   addr_q, rdata_q;
  logic [SCNT_W-1:0]           scan_cnt_q, scan_cnt_d;
  logic [IDX_W-1:0]            cmp_idx_q, cmp_idx_d, free_idx_q, free_idx_d;
  logic                        cmp_vld_q, cmp_vld_d, found_q, found_d;
  logic                        free_vld_q, free_vld_d;
  logic                        cmp_hit, commit_wr;

  // Window counters and search state.
  logic [CNT_W-1:0]   useful_q, unused_q, timely_q, late_q;
  logic [CNT_W-1:0]   useful_d, unused_d, timely_d, late_d;
  logic [WIN_W-1:0]   issued_q, issued_d;
  logic [DEPTH_W-1:0] depth_q, depth_d, before_q, conv_u_q, conv_u_d, conv_t_q, conv_t_d;
  logic [1:0]         last_dir_q, last_dir_d;
  logic               stage_q, stage_d, closed_q, closed_d;

  // Evaluation and regression registers.
  logic [43:0]          lhs_q, rhs_q;
  logic                 tot_nz_q;
  logic [13:0]          prod_q;
  logic signed [16:0]   coef_q;
  logic signed [31:0]   acc_q, acc_d;

  // Combinational helpers.
  logic [WIN_W:0]       issued_n, limit;
  logic                 win_close, sel_time, samples, do_search, conv;
  logic [CNT_W-1:0]     hits, other;
  logic [CNT_W:0]       total;
  logic [TGT_W-1:0]     target;
  logic [1:0]           dir;
  logic [DEPTH_W-1:0]   emin, emax, up_next, dn_next, seek_next, term_x, term_y;
  logic [DEPTH_W:0]     up_sum;
  logic signed [31:0]   term_val, acc_rnd;
  logic [9:0]           reg_d;

  assign emin = eff_min(cfg_i.lo_depth);
  assign emax = eff_max(cfg_i.hi_depth);

  // Entry compare on the registered read data.
  assign cmp_hit   = cmp_vld_q && valid_q[cmp_idx_q] && (rdata_q == addr_q);
  assign commit_wr = ctrl_i.table_commit && !found_q && free_vld_q;

  // Scan sequencing: one table entry read per cycle.
  always_comb begin
    scan_cnt_d = scan_cnt_q;
    cmp_vld_d  = cmp_vld_q;
    cmp_idx_d  = cmp_idx_q;
    found_d    = found_q;
    free_vld_d = free_vld_q;
    free_idx_d = free_idx_q;
    valid_d    = valid_q;
    if (ctrl_i.load) begin
      scan_cnt_d = '0;
      cmp_vld_d  = 1'b0;
      found_d    = 1'b0;
      free_vld_d = 1'b0;
    end else if (ctrl_i.scan_step) begin
      if (scan_cnt_q != SCAN_END) begin
        scan_cnt_d = scan_cnt_q + SCNT_W'(1);
        cmp_vld_d  = 1'b1;
        cmp_idx_d  = scan_cnt_q[IDX_W-1:0];
      end else begin
        cmp_vld_d = 1'b0;
      end
    end
    if (cmp_vld_q) begin
      if (cmp_hit) begin
        found_d = 1'b1;
        if (!ctrl_i.scan_insert) valid_d[cmp_idx_q] = 1'b0;
      end
      if (!valid_q[cmp_idx_q] && !free_vld_q) begin
        free_vld_d = 1'b1;
        free_idx_d = cmp_idx_q;
      end
    end
    if (commit_wr) valid_d[free_idx_q] = 1'b1;
  end

  // Table memory: one registered read port, one write port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_step && (scan_cnt_q != SCAN_END)) begin
      rdata_q <= mem[scan_cnt_q[IDX_W-1:0]];
    end
    if (commit_wr) begin
      mem[free_idx_q] <= addr_q;
    end
  end

  // Window length check; zero means 65536 issues.
  assign issued_n  = {1'b0, issued_q} + (WIN_W + 1)'(1);
  assign limit     = (cfg_i.window == '0) ? {1'b1, {WIN_W{1'b0}}} : {1'b0, cfg_i.window};
  assign win_close = issued_n >= limit;

  // Ratio selection for the active search.
  assign sel_time  = (cfg_i.policy == POL_TIME) || ((cfg_i.policy == POL_BOTH) && stage_q);
  assign hits      = sel_time ? timely_q : useful_q;
  assign other     = sel_time ? late_q : unused_q;
  assign total     = {1'b0, hits} + {1'b0, other};
  assign target    = sel_time ? cfg_i.tgt_time : cfg_i.tgt_util;
  assign samples   = (useful_q != '0) || (unused_q != '0) || (timely_q != '0) || (late_q != '0);
  assign do_search = samples && (cfg_i.policy != POL_RSVD);

  // One search step from the registered cross products.
  always_comb begin
    if (!tot_nz_q)          dir = DIR_NONE;
    else if (lhs_q > rhs_q) dir = DIR_UP;
    else if (lhs_q < rhs_q) dir = DIR_DOWN;
    else                    dir = DIR_NONE;
    conv = (dir == DIR_NONE) || ((last_dir_q != DIR_NONE) && (dir != last_dir_q)) ||
           ((dir == DIR_UP) && (depth_q == emax)) || ((dir == DIR_DOWN) && (depth_q == emin));
    up_sum  = {1'b0, depth_q} + {1'b0, cfg_i.step};
    up_next = (up_sum > {1'b0, emax}) ? emax : up_sum[DEPTH_W-1:0];
    dn_next = (depth_q > cfg_i.step) ? depth_q - cfg_i.step : emin;
    if (dn_next < emin) dn_next = emin;
    seek_next = clamp_depth(10'((dir == DIR_UP) ? up_next : dn_next), emin, emax);
  end

  // Regression term operands.
  always_comb begin
    case (ctrl_i.term)
      TERM_A:  begin term_x = conv_u_q; term_y = DEPTH_W'(1); end
      TERM_T:  begin term_x = conv_t_q; term_y = DEPTH_W'(1); end
      TERM_AA: begin term_x = conv_u_q; term_y = conv_u_q;    end
      TERM_TT: begin term_x = conv_t_q; term_y = conv_t_q;    end
      default: begin term_x = conv_u_q; term_y = conv_t_q;    end
    endcase
  end

  assign term_val = coef_q * $signed({1'b0, prod_q});
  assign acc_rnd  = acc_q + 32'sd32768;
  assign reg_d    = (acc_q > 32'sd0) ? acc_rnd[25:16] : 10'd0;

  // Next state of counters, depth and search.
  always_comb begin
    useful_d   = useful_q;
    unused_d   = unused_q;
    timely_d   = timely_q;
    late_d     = late_q;
    issued_d   = issued_q;
    depth_d    = depth_q;
    last_dir_d = last_dir_q;
    conv_u_d   = conv_u_q;
    conv_t_d   = conv_t_q;
    stage_d    = stage_q;
    closed_d   = closed_q;
    acc_d      = acc_q;
    if (ctrl_i.load) closed_d = 1'b0;
    if (ctrl_i.inc_pref_hit) begin
      useful_d = sat_inc(useful_q);
      timely_d = sat_inc(timely_q);
    end
    if (ctrl_i.inc_late_hit) begin
      useful_d = sat_inc(useful_q);
      late_d   = sat_inc(late_q);
    end
    if (ctrl_i.inc_unused) unused_d = sat_inc(unused_q);
    if (ctrl_i.issue_step) issued_d = issued_n[WIN_W-1:0];
    if (init_load_i) depth_d = clamp_depth(10'(cfg_i.init_depth), emin, emax);
    if (ctrl_i.eval_seek) begin
      closed_d = 1'b1;
      acc_d    = '0;
      issued_d = '0;
      useful_d = '0;
      unused_d = '0;
      timely_d = '0;
      late_d   = '0;
      if (do_search) begin
        if (conv) begin
          last_dir_d = DIR_NONE;
          if (sel_time) conv_t_d = depth_q;
          else          conv_u_d = depth_q;
          if ((cfg_i.policy == POL_BOTH) && !stage_q) stage_d = 1'b1;
        end else begin
          last_dir_d = dir;
          depth_d    = seek_next;
        end
      end
    end
    if (ctrl_i.reg_acc) acc_d = acc_q + term_val;
    if (ctrl_i.reg_fin) begin
      depth_d = clamp_depth(reg_d, emin, emax);
      stage_d = 1'b0;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      scan_cnt_q <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      found_q    <= 1'b0;
      free_vld_q <= 1'b0;
      free_idx_q <= '0;
      useful_q   <= '0;
      unused_q   <= '0;
      timely_q   <= '0;
      late_q     <= '0;
      issued_q   <= '0;
      depth_q    <= clamp_depth(10'(RST_INIT_DEPTH), eff_min(RST_MIN_DEPTH),
                                eff_max(RST_MAX_DEPTH));
      last_dir_q <= DIR_NONE;
      conv_u_q   <= '0;
      conv_t_q   <= '0;
      stage_q    <= 1'b0;
      closed_q   <= 1'b0;
      acc_q      <= '0;
    end else begin
      valid_q    <= valid_d;
      scan_cnt_q <= scan_cnt_d;
      cmp_vld_q  <= cmp_vld_d;
      cmp_idx_q  <= cmp_idx_d;
      found_q    <= found_d;
      free_vld_q <= free_vld_d;
      free_idx_q <= free_idx_d;
      useful_q   <= useful_d;
      unused_q   <= unused_d;
      timely_q   <= timely_d;
      late_q     <= late_d;
      issued_q   <= issued_d;
      depth_q    <= depth_d;
      last_dir_q <= last_dir_d;
      conv_u_q   <= conv_u_d;
      conv_t_q   <= conv_t_d;
      stage_q    <= stage_d;
      closed_q   <= closed_d;
      acc_q      <= acc_d;
    end
  end

  // Payload registers: event address, depth before, products.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      addr_q   <= line_addr_i;
      before_q <= depth_q;
    end
    if (ctrl_i.eval_mul) begin
      lhs_q    <= {2'b00, hits, 10'd0};
      rhs_q    <= {33'd0, target} * {11'd0, total};
      tot_nz_q <= (total != '0);
    end
    if (ctrl_i.reg_mul) begin
      prod_q <= term_x * term_y;
      coef_q <= term_coef(ctrl_i.term);
    end
  end

  // Status and result fields.
  assign stat_o.scan_done = (scan_cnt_q == SCAN_END) && !cmp_vld_q;
  assign stat_o.found     = found_q;
  assign stat_o.win_close = win_close;
  assign stat_o.regress   = do_search && conv && (cfg_i.policy == POL_BOTH) && stage_q;

  assign depth_o         = depth_q;
  assign depth_changed_o = depth_q != before_q;
  assign window_closed_o = closed_q;
  assign search_stage_o  = stage_q;

endmodule

`default_nettype wire

@@ sv/aft_ctrl.sv @@
// Controller state machine that sequences table scans, window evaluation and regression.
`timescale 1ns / 1ps
`default_nettype none

module aft_ctrl
  import aft_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire evt_t  evt_i,
  input  wire stat_t stat_i,
  input  wire logic  out_free_i,
  output logic       in_ready_o,
  output ctrl_t      ctrl_o,
  output logic       out_load_o
);

  localparam logic [TERM_W-1:0] TERM_LAST = TERM_W'(NUM_TERMS - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_POST, ST_EMUL, ST_ESEEK, ST_RMUL, ST_RACC, ST_RFIN, ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    MODE_RM, MODE_RM_CNT, MODE_INS
  } mode_e;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [TERM_W-1:0] term_q, term_d;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    term_d      = term_q;
    ctrl_o      = '0;
    ctrl_o.term = term_q;
    out_load_o  = 1'b0;
    in_ready_o  = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          case (evt_i.cmd)
            CMD_DEMAND: begin
              if (evt_i.pref) begin
                ctrl_o.inc_pref_hit = 1'b1;
                mode_d  = MODE_RM;
                state_d = ST_SCAN;
              end else if (evt_i.miss && evt_i.mq) begin
                mode_d  = MODE_RM_CNT;
                state_d = ST_SCAN;
              end else begin
                state_d = ST_FIN;
              end
            end
            CMD_FILL: begin
              mode_d  = MODE_RM;
              state_d = ST_SCAN;
            end
            CMD_UNUSED: begin
              ctrl_o.inc_unused = 1'b1;
              state_d = ST_FIN;
            end
            CMD_ISSUE: begin
              mode_d  = MODE_INS;
              state_d = ST_SCAN;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_SCAN: begin
        ctrl_o.scan_step   = 1'b1;
        ctrl_o.scan_insert = (mode_q == MODE_INS);
        if (stat_i.scan_done) state_d = ST_POST;
      end
      ST_POST: begin
        ctrl_o.scan_insert = (mode_q == MODE_INS);
        state_d = ST_FIN;
        case (mode_q)
          MODE_RM_CNT: ctrl_o.inc_late_hit = stat_i.found;
          MODE_INS: begin
            ctrl_o.table_commit = 1'b1;
            if (stat_i.win_close) state_d = ST_EMUL;
            else ctrl_o.issue_step = 1'b1;
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_EMUL: begin
        ctrl_o.eval_mul = 1'b1;
        state_d = ST_ESEEK;
      end
      ST_ESEEK: begin
        ctrl_o.eval_seek = 1'b1;
        if (stat_i.regress) begin
          term_d  = '0;
          state_d = ST_RMUL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_RMUL: begin
        ctrl_o.reg_mul = 1'b1;
        state_d = ST_RACC;
      end
      ST_RACC: begin
        ctrl_o.reg_acc = 1'b1;
        if (term_q == TERM_LAST) begin
          state_d = ST_RFIN;
        end else begin
          term_d  = term_q + TERM_W'(1);
          state_d = ST_RMUL;
        end
      end
      ST_RFIN: begin
        ctrl_o.reg_fin = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and sequencing registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_RM;
      term_q  <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      term_q  <= term_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/adaptive_fetch_queue_depth_tuner_top.sv @@
// Top level of the adaptive fetch queue depth tuner.
`timescale 1ns / 1ps
`default_nettype none

// Each cache event on the input stream yields one result carrying the fetch
// queue depth after that event. Demand events that need no table lookup and
// unused-prefetch events go from the idle state straight to the result.
// Fills, issued prefetches and demand events that consult the in-flight line
// table scan it one entry per cycle through its single read port. An issued
// prefetch that closes a measurement window then runs the ratio compare, and
// the quadratic regression, when it runs, on its shared multiplier. The block
// takes one event at a time; a finished result waits in the output register
// while the next event is taken.
module adaptive_fetch_queue_depth_tuner_top
  import aft_pkg::*;
#(
  parameter int unsigned QUEUE_CAPACITY   = QUEUE_CAPACITY_DEF,
  parameter int unsigned INFLIGHT_ENTRIES = INFLIGHT_ENTRIES_DEF,
  parameter int unsigned LINE_ADDR_BITS   = LINE_ADDR_BITS_DEF,
  localparam int unsigned IN_DATA_W       = ((LINE_ADDR_BITS + 3 + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  // Event stream.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // line_addr, was_prefetched, cache_miss, in_miss_queue, zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  wire logic [1:0]            s_axis_tuser,
  // Result stream.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // depth, depth_changed, window_closed, search_stage, zero fill
  output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

  cfg_t               cfg;
  logic               init_load;
  ctrl_t              ctrl;
  stat_t              stat;
  evt_t               evt;
  logic               out_load, out_free;
  logic [DEPTH_W-1:0] depth;
  logic               depth_changed, window_closed, search_stage;
  logic               m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q;

  // Event flags for the controller.
  assign evt.cmd  = cmd_e'(s_axis_tuser);
  assign evt.pref = s_axis_tdata[LINE_ADDR_BITS];
  assign evt.miss = s_axis_tdata[LINE_ADDR_BITS + 1];
  assign evt.mq   = s_axis_tdata[LINE_ADDR_BITS + 2];

  aft_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .init_load_o (init_load)
  );

  aft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .evt_i      (evt),
    .stat_i     (stat),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl),
    .out_load_o (out_load)
  );

  aft_datapath #(
    .QUEUE_CAPACITY   (QUEUE_CAPACITY),
    .INFLIGHT_ENTRIES (INFLIGHT_ENTRIES),
    .LINE_ADDR_BITS   (LINE_ADDR_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .init_load_i     (init_load),
    .ctrl_i          (ctrl),
    .line_addr_i     (s_axis_tdata[LINE_ADDR_BITS-1:0]),
    .stat_o          (stat),
    .depth_o         (depth),
    .depth_changed_o (depth_changed),
    .window_closed_o (window_closed),
    .search_stage_o  (search_stage)
  );

  // Output register: holds a result until its transfer completes.
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load)           m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {6'd0, search_stage, window_closed, depth_changed, depth};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  // A delivered depth is never zero.
  a_depth_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[DEPTH_W-1:0] != '0))
    else $error("result depth is zero");

  // Events are processed one at a time.
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("event accepted while another is in progress");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ sim/depth_tuner_checker.sv @@
// Checker for the fetch queue depth tuner: predicts each result and compares it.
`timescale 1ns / 1ps

module depth_tuner_checker
  import aft_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [47:0]           s_tdata_i,
  input  logic [1:0]            s_tuser_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  output int                    fail_count_o,
  output int                    results_owed_o
);

  localparam int TABLE_SIZE = 64;
  localparam int DEPTH_CAP  = 64;

  typedef struct packed {
    logic       stage;
    logic       closed;
    logic       changed;
    logic [6:0] depth;
  } depth_result_t;

  // Register copies.
  logic [1:0]  policy;
  logic [6:0]  init_depth, lo_bound, hi_bound, step;
  logic [15:0] win_len;
  logic [10:0] util_goal, time_goal;

  // Tuner state.
  int unsigned depth, direction, stage, conv_util, conv_time, issues;
  logic [31:0] n_useful, n_unused, n_timely, n_late;
  logic        line_valid [TABLE_SIZE];
  logic [41:0] line_addr [TABLE_SIZE];

  depth_result_t owed_results[$];

  function automatic int unsigned hi_eff();
    int unsigned m;
    m = hi_bound;
    if (m > DEPTH_CAP) m = DEPTH_CAP;
    return (m == 0) ? 1 : m;
  endfunction

  function automatic int unsigned lo_eff();
    return (lo_bound == 0) ? 1 : lo_bound;
  endfunction

  function automatic int unsigned bound_depth(int unsigned d);
    if (d < lo_eff()) d = lo_eff();
    if (d > hi_eff()) d = hi_eff();
    return d;
  endfunction

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic bit drop_line(logic [41:0] a);
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (line_valid[i] && line_addr[i] == a) begin
        line_valid[i] = 1'b0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // A present line is kept once; a full table drops the new line.
  function automatic void add_line(logic [41:0] a);
    int slot;
    slot = -1;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (line_valid[i] && line_addr[i] == a) return;
      if (!line_valid[i] && slot < 0) slot = i;
    end
    if (slot >= 0) begin
      line_valid[slot] = 1'b1;
      line_addr[slot]  = a;
    end
  endfunction

  // One search step toward a ratio target; returns 1 when converged.
  function automatic bit search_step(longint unsigned hits, longint unsigned total,
                                     int unsigned goal, inout int unsigned conv);
    int unsigned dir, nxt;
    longint unsigned lhs, rhs;
    dir = DIR_NONE;
    if (total != 0) begin
      lhs = hits * 1024;
      rhs = longint'(goal) * total;
      dir = (lhs > rhs) ? DIR_UP : (lhs < rhs) ? DIR_DOWN : DIR_NONE;
    end
    if (dir == DIR_NONE || (direction != DIR_NONE && dir != direction) ||
        (dir == DIR_UP && depth == hi_eff()) || (dir == DIR_DOWN && depth == lo_eff())) begin
      conv      = depth;
      direction = DIR_NONE;
      return 1'b1;
    end
    direction = dir;
    if (dir == DIR_UP) begin
      nxt = depth + step;
      if (nxt > hi_eff()) nxt = hi_eff();
    end else begin
      nxt = (depth > step) ? depth - step : lo_eff();
      if (nxt < lo_eff()) nxt = lo_eff();
    end
    depth = bound_depth(nxt);
    return 1'b0;
  endfunction

  // Window close: search, and in the combined policy finish with the regression.
  function automatic void close_window();
    longint unsigned us, ts;
    longint a, t, q;
    int unsigned d, c;
    us = longint'(n_useful) + longint'(n_unused);
    ts = longint'(n_timely) + longint'(n_late);
    if (us != 0 || ts != 0) begin
      if (policy == POL_UTIL) begin
        c = conv_util;
        void'(search_step(n_useful, us, util_goal, c));
        conv_util = c;
      end else if (policy == POL_TIME) begin
        c = conv_time;
        void'(search_step(n_timely, ts, time_goal, c));
        conv_time = c;
      end else if (policy == POL_BOTH) begin
        if (stage == 0) begin
          c = conv_util;
          if (search_step(n_useful, us, util_goal, c)) stage = 1;
          conv_util = c;
        end else begin
          c = conv_time;
          if (search_step(n_timely, ts, time_goal, c)) begin
            conv_time = c;
            a = conv_util;
            t = conv_time;
            q = -22282 * a + 41943 * t + 524 * a * a + 655 * t * t - 524 * a * t;
            d = 0;
            if (q > 0) d = (q + 32768) >>> 16;
            depth = bound_depth(d);
            stage = 0;
          end
          conv_time = c;
        end
      end
    end
    issues   = 0;
    n_useful = '0;
    n_unused = '0;
    n_timely = '0;
    n_late   = '0;
  endfunction

  function automatic depth_result_t predict_event(cmd_e cmd, logic [47:0] d);
    depth_result_t r;
    logic [41:0] line;
    int unsigned prior, limit;
    bit shut;
    line  = d[41:0];
    prior = depth;
    shut  = 1'b0;
    case (cmd)
      CMD_DEMAND: begin
        if (d[42]) begin
          n_useful = bump(n_useful);
          n_timely = bump(n_timely);
          void'(drop_line(line));
        end else if (d[43] && d[44] && drop_line(line)) begin
          n_useful = bump(n_useful);
          n_late   = bump(n_late);
        end
      end
      CMD_FILL:   void'(drop_line(line));
      CMD_UNUSED: n_unused = bump(n_unused);
      default: begin
        add_line(line);
        limit = (win_len == 0) ? 65536 : win_len;
        if (issues + 1 >= limit) begin
          close_window();
          shut = 1'b1;
        end else begin
          issues++;
        end
      end
    endcase
    r.depth   = depth[6:0];
    r.changed = (depth != prior);
    r.closed  = shut;
    r.stage   = stage[0];
    return r;
  endfunction

  assign results_owed_o = owed_results.size();

  // Follow register writes, predict accepted events and check results.
  always @(posedge clk_i or negedge rst_ni) begin
    depth_result_t want, got;
    if (!rst_ni) begin
      policy      = RST_POLICY;
      init_depth  = RST_INIT_DEPTH;
      lo_bound    = RST_MIN_DEPTH;
      hi_bound    = RST_MAX_DEPTH;
      step        = RST_STEP;
      win_len     = RST_WINDOW;
      util_goal   = RST_TGT_UTIL;
      time_goal   = RST_TGT_TIME;
      depth       = RST_INIT_DEPTH;
      direction   = DIR_NONE;
      stage       = 0;
      conv_util   = 0;
      conv_time   = 0;
      issues      = 0;
      n_useful    = '0;
      n_unused    = '0;
      n_timely    = '0;
      n_late      = '0;
      for (int i = 0; i < TABLE_SIZE; i++) line_valid[i] = 1'b0;
      owed_results.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_POLICY:   policy    = pwdata[1:0];
          REG_INIT: begin
            init_depth = pwdata[6:0];
            depth      = bound_depth(init_depth);
          end
          REG_MIN:      lo_bound  = pwdata[6:0];
          REG_MAX:      hi_bound  = pwdata[6:0];
          REG_STEP:     step      = pwdata[6:0];
          REG_WINDOW:   win_len   = pwdata[15:0];
          REG_TGT_UTIL: util_goal = pwdata[10:0];
          REG_TGT_TIME: time_goal = pwdata[10:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[9:0];
        if (owed_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o < 40)
            $display("%0t: result with none owed, actual %h", $time, got);
        end else begin
          want = owed_results.pop_front();
          if (want.depth != got.depth || want.changed != got.changed ||
              want.closed != got.closed || want.stage != got.stage) begin
            fail_count_o++;
            if (fail_count_o < 40)
              $display("%0t: depth/changed/closed/stage expected %0d/%b/%b/%b actual %0d/%b/%b/%b",
                       $time, want.depth, want.changed, want.closed, want.stage,
                       got.depth, got.changed, got.closed, got.stage);
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        owed_results.push_back(predict_event(cmd_e'(s_tuser_i), s_tdata_i));
    end
  end

endmodule

@@ sim/testbench.sv @@
// Stimulus and verdict for the fetch queue depth tuner.
`timescale 1ns / 1ps

module testbench;
  import aft_pkg::*;

  localparam int POOL_SIZE = 80;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;
  logic                  s_tvalid, s_tready, m_tvalid, m_tready;
  logic [47:0]           s_tdata;
  logic [1:0]            s_tuser;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    fail_count, results_owed;
  int                    burst_left, ready_pct;
  logic [41:0]           line_pool [POOL_SIZE];

  adaptive_fetch_queue_depth_tuner_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  depth_tuner_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .s_tvalid_i     (s_tvalid),
    .s_tready_i     (s_tready),
    .s_tdata_i      (s_tdata),
    .s_tuser_i      (s_tuser),
    .m_tvalid_i     (m_tvalid),
    .m_tready_i     (m_tready),
    .m_tdata_i      (m_tdata),
    .fail_count_o   (fail_count),
    .results_owed_o (results_owed)
  );

  // Clock with a 12 ns period.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // The result side stalls at a rate that changes from phase to phase.
  always @(posedge clk_i) begin
    m_tready <= rst_ni && ($urandom_range(0, 99) < ready_pct);
  end

  // Register write: setup cycle, then access cycle.
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Let every owed result arrive and the block fall idle.
  task automatic drain();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (results_owed != 0) @(negedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // The initial depth goes last so that it is clamped to the new bounds.
  task automatic set_policy(int pol, int init, int lo, int hi, int stp, int win,
                            int tu, int tt);
    drain();
    reg_write(REG_POLICY, pol);
    reg_write(REG_MIN, lo);
    reg_write(REG_MAX, hi);
    reg_write(REG_STEP, stp);
    reg_write(REG_WINDOW, win);
    reg_write(REG_TGT_UTIL, tu);
    reg_write(REG_TGT_TIME, tt);
    reg_write(REG_INIT, init);
  endtask

  // Send one event; bursts of random length are separated by random gaps.
  // Ready is sampled mid-cycle so the transfer edge is known exactly.
  task automatic send_event(cmd_e cmd, logic [41:0] line, bit pref, bit miss, bit mq);
    bit rdy;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, mq, miss, pref, line};
    do begin
      @(negedge clk_i);
      rdy = s_tready;
      @(posedge clk_i);
    end while (!rdy);
    burst_left--;
  endtask

  task automatic random_events(int count);
    int r;
    logic [41:0] line;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) line = {$urandom, $urandom};
      else line = line_pool[$urandom_range(0, POOL_SIZE - 1)];
      r = $urandom_range(0, 99);
      if (r < 35)
        send_event(CMD_DEMAND, line, $urandom_range(0, 3) == 0, $urandom_range(0, 1),
                   $urandom_range(0, 1));
      else if (r < 45)
        send_event(CMD_FILL, line, $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 1));
      else if (r < 62)
        send_event(CMD_UNUSED, line, $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 1));
      else
        send_event(CMD_ISSUE, line, $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 1));
      if (i == count / 2 && count > 50) drain();
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = CMD_DEMAND;
    burst_left = 0;
    ready_pct  = 100;
    for (int i = 0; i < POOL_SIZE; i++) line_pool[i] = {$urandom, $urandom};
    line_pool[0] = '0;
    line_pool[1] = '1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short directed sequence with a window of four issues.
    set_policy(POL_BOTH, 16, 4, 64, 4, 4, 512, 512);
    send_event(CMD_ISSUE, line_pool[0], 0, 0, 0);
    send_event(CMD_ISSUE, line_pool[1], 1, 1, 1);
    send_event(CMD_DEMAND, line_pool[0], 1, 0, 0);    // timely useful hit
    send_event(CMD_DEMAND, line_pool[1], 0, 1, 1);    // late useful hit
    send_event(CMD_DEMAND, line_pool[2], 0, 1, 1);    // pending miss, not in flight
    send_event(CMD_DEMAND, line_pool[3], 0, 1, 0);
    send_event(CMD_FILL, line_pool[4], 0, 0, 0);
    send_event(CMD_UNUSED, line_pool[5], 0, 0, 0);
    send_event(CMD_ISSUE, line_pool[2], 0, 0, 0);
    send_event(CMD_ISSUE, line_pool[2], 0, 0, 0);     // duplicate closes the window
    send_event(CMD_FILL, line_pool[2], 0, 0, 0);
    send_event(CMD_DEMAND, line_pool[2], 0, 1, 1);    // already filled
    for (int i = 0; i < 8; i++) send_event(CMD_ISSUE, line_pool[6 + i], 0, 0, 0);
    send_event(CMD_DEMAND, line_pool[6], 1, 1, 1);
    ready_pct = 60;
    random_events(90);

    // Extreme settings, crossed bounds, the unused policy and a long window.
    ready_pct = 100;
    set_policy(POL_UTIL, 64, 1, 64, 64, 1, 0, 1024);
    random_events(100);
    ready_pct = 20;
    set_policy(POL_TIME, 1, 1, 1, 1, 2, 1024, 0);
    random_events(100);
    ready_pct = 70;
    set_policy(POL_BOTH, 40, 50, 20, 3, 3, 300, 700);
    random_events(100);
    set_policy(POL_RSVD, 20, 4, 60, 5, 2, 512, 512);
    random_events(80);
    ready_pct = 90;
    set_policy(POL_BOTH, 30, 1, 64, 1, 65535, 1024, 1024);
    random_events(80);

    // Random settings.
    for (int p = 0; p < 9; p++) begin
      ready_pct = $urandom_range(15, 100);
      set_policy($urandom_range(0, 5) == 0 ? POL_RSVD : $urandom_range(0, 2),
                 $urandom_range(1, 64), $urandom_range(1, 24), $urandom_range(1, 64),
                 $urandom_range(1, 12), $urandom_range(1, 12),
                 $urandom_range(0, 1024), $urandom_range(0, 1024));
      random_events(100);
    end

    drain();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #15000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
sv/aft_pkg.sv
sv/aft_regs.sv
sv/aft_datapath.sv
sv/aft_ctrl.sv
sv/adaptive_fetch_queue_depth_tuner_top.sv
sim/depth_tuner_checker.sv
sim/testbench.sv
